FILE: rtl/fcomp_pkg.sv
// Package: shared types and constants of the focus temperature compensator.
`timescale 1ns / 1ps
`default_nettype none

package fcomp_pkg;

    localparam int TEMP_W  = 12;
    localparam int POS_W   = 32;
    localparam int COEF_W  = 16;
    localparam int CFG_W   = 32;
    localparam int CFG_IDX_W = 3;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 48;

    // Temperatures are 1/16 C two's complement
    localparam logic signed [TEMP_W-1:0] TEMP_LOW_LIMIT  = -12'sd640;
    localparam logic signed [TEMP_W-1:0] TEMP_HIGH_LIMIT = 12'sd1280;
    localparam logic signed [TEMP_W:0]   ONE_DEGREE      = 13'sd16;
    localparam logic [POS_W-1:0]         MAX_POS_RESET   = 32'd80000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROBE_ENABLED    = 3'd0,
        CFG_PROBE_PRESENT    = 3'd1,
        CFG_COMP_ENABLE      = 3'd2,
        CFG_COMP_DIRECTION   = 3'd3,
        CFG_STEP_COEFFICIENT = 3'd4,
        CFG_MAX_POSITION     = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic              probe_enabled;
        logic              probe_present;
        logic              comp_enable;
        logic              comp_direction;
        logic [COEF_W-1:0] step_coefficient;
        logic [POS_W-1:0]  max_position;
    } t_cfg;

    typedef struct packed {
        logic signed [TEMP_W-1:0] reported_temp;
        logic                     conversion_request;
        logic                     target_moved;
        logic [POS_W-1:0]         new_target;
    } t_result;

endpackage : fcomp_pkg

`default_nettype wire

FILE: rtl/focus_temperature_compensator_top.sv
// Top level of the focus temperature compensator: stream ports, input and result registers.
//
// Channel   Dir  Handshake                   Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tick: sensor_reading, target_position
// m_axis    out  m_axis_tvalid/m_axis_tready  result: new_target, target_moved,
//                                             conversion_request, reported_temp
// cfg       in   i_cfg_we (no handshake)      register index and write data
//
// One result per tick; a tick passes from the input register through the compensation
// logic into the result register, which drives m_axis.
// Sustained rate is one tick per cycle while m_axis_tready stays high; probe state updates
// as a tick leaves the input register, so consecutive ticks chain through it without bubbles.
// Reset (i_rst_n low, synchronous) empties both registers and clears probe state;
// max_position resets to 80000, all other configuration registers to zero.
// A stalled output holds the result register and the input register fills behind it;
// s_axis_tready drops once both are occupied.
`timescale 1ns / 1ps
`default_nettype none

module focus_temperature_compensator_top (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // tdata: [11:0] sensor_reading, [43:12] target_position, [47:44] zero
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [fcomp_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // tdata: [31:0] new_target, [32] target_moved, [33] conversion_request,
    //        [45:34] reported_temp, [47:46] zero
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    output logic [fcomp_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
    input  wire logic                               i_cfg_we,
    input  wire logic [fcomp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [fcomp_pkg::CFG_W-1:0]        i_cfg_data
);
    import fcomp_pkg::*;

    t_cfg    w_cfg;
    t_result w_result;

    // Input register
    logic                     r_in_valid;
    logic signed [TEMP_W-1:0] r_sensor_reading;
    logic [POS_W-1:0]         r_target_position;

    // Result register
    logic                     r_out_valid;
    t_result                  r_result;

    logic w_out_free;   // result register can take a new result this cycle
    logic w_advance;    // input register moves into the result register

    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_advance     = r_in_valid && w_out_free;
    assign s_axis_tready = !r_in_valid || w_out_free;

    fcomp_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    fcomp_core u_core (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (w_advance),
        .i_cfg             (w_cfg),
        .i_sensor_reading  (r_sensor_reading),
        .i_target_position (r_target_position),
        .o_result          (w_result)
    );

    // Control: valid flags of both registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (w_out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // Payload: capture on transfer, hold otherwise
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_sensor_reading  <= s_axis_tdata[TEMP_W-1:0];
            r_target_position <= s_axis_tdata[TEMP_W+POS_W-1:TEMP_W];
        end
        if (w_advance) begin
            r_result <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W-POS_W-2-TEMP_W){1'b0}},
                            r_result.reported_temp,
                            r_result.conversion_request,
                            r_result.target_moved,
                            r_result.new_target};

    // A held tick in the input register is not lost while the output stalls
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_out_free) |=> r_in_valid)
        else $error("input tick dropped during output stall");

    // A waiting result is never overwritten
    a_out_keep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |=> (r_out_valid && $stable(r_result)))
        else $error("pending result overwritten");

endmodule : focus_temperature_compensator_top

`default_nettype wire

FILE: rtl/fcomp_cfg.sv
// Configuration register file of the focus temperature compensator.
`timescale 1ns / 1ps
`default_nettype none

module fcomp_cfg (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [fcomp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [fcomp_pkg::CFG_W-1:0]     i_cfg_data,
    output fcomp_pkg::t_cfg                     o_cfg
);
    import fcomp_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_PROBE_ENABLED:    n_cfg.probe_enabled    = i_cfg_data[0];
                CFG_PROBE_PRESENT:    n_cfg.probe_present    = i_cfg_data[0];
                CFG_COMP_ENABLE:      n_cfg.comp_enable      = i_cfg_data[0];
                CFG_COMP_DIRECTION:   n_cfg.comp_direction   = i_cfg_data[0];
                CFG_STEP_COEFFICIENT: n_cfg.step_coefficient = i_cfg_data[COEF_W-1:0];
                CFG_MAX_POSITION:     n_cfg.max_position     = i_cfg_data[POS_W-1:0];
                default:              n_cfg = r_cfg;  // unused index: ignore
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.probe_enabled    <= 1'b0;
            r_cfg.probe_present    <= 1'b0;
            r_cfg.comp_enable      <= 1'b0;
            r_cfg.comp_direction   <= 1'b0;
            r_cfg.step_coefficient <= '0;
            r_cfg.max_position     <= MAX_POS_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule : fcomp_cfg

`default_nettype wire

FILE: rtl/fcomp_core.sv
// Compensation datapath and probe state of the focus temperature compensator.
`timescale 1ns / 1ps
`default_nettype none

module fcomp_core (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    input  fcomp_pkg::t_cfg                      i_cfg,
    input  wire logic signed [fcomp_pkg::TEMP_W-1:0] i_sensor_reading,
    input  wire logic [fcomp_pkg::POS_W-1:0]     i_target_position,
    output fcomp_pkg::t_result                   o_result
);
    import fcomp_pkg::*;

    logic signed [TEMP_W-1:0] r_last_good_temp, n_last_good_temp;
    logic signed [TEMP_W-1:0] r_held_reading,   n_held_reading;
    logic signed [TEMP_W-1:0] r_reference_temp, n_reference_temp;
    logic                     r_read_phase,     n_read_phase;
    logic                     r_seen_comp,      n_seen_comp;

    logic                     w_active;
    logic                     w_in_range;
    logic signed [TEMP_W-1:0] w_reading;
    logic                     w_switch_on;
    logic signed [TEMP_W-1:0] w_ref;
    logic signed [TEMP_W-1:0] w_held;
    logic signed [TEMP_W:0]   w_diff;
    logic                     w_event;
    logic                     w_outward;
    logic signed [POS_W+1:0]  w_pos;
    logic signed [POS_W+1:0]  w_max;
    logic [POS_W-1:0]         w_target;

    always_comb begin
        w_active    = i_cfg.probe_enabled && i_cfg.probe_present;
        w_in_range  = (i_sensor_reading > TEMP_LOW_LIMIT) &&
                      (i_sensor_reading < TEMP_HIGH_LIMIT);
        w_reading   = w_in_range ? i_sensor_reading : r_last_good_temp;
        w_switch_on = (i_cfg.comp_enable != r_seen_comp) && i_cfg.comp_enable;

        // Reference latches on switch-on before the phase action
        w_ref  = w_switch_on  ? w_reading : r_reference_temp;
        w_held = r_read_phase ? w_reading : r_held_reading;

        w_diff  = {w_ref[TEMP_W-1], w_ref} - {w_held[TEMP_W-1], w_held};
        w_event = i_cfg.comp_enable && ((w_diff >= ONE_DEGREE) || (w_diff <= -ONE_DEGREE));
        // Temperature fell when held reading lies below the reference
        w_outward = i_cfg.comp_direction ? (w_held < w_ref) : !(w_held < w_ref);

        w_pos = w_outward
              ? $signed({2'b00, i_target_position}) + $signed({18'd0, i_cfg.step_coefficient})
              : $signed({2'b00, i_target_position}) - $signed({18'd0, i_cfg.step_coefficient});
        w_max = $signed({2'b00, i_cfg.max_position});
        if (w_pos > w_max) begin
            w_target = i_cfg.max_position;
        end else if (w_pos[POS_W+1]) begin
            w_target = '0;
        end else begin
            w_target = w_pos[POS_W-1:0];
        end

        n_last_good_temp = r_last_good_temp;
        n_held_reading   = r_held_reading;
        n_reference_temp = r_reference_temp;
        n_read_phase     = r_read_phase;
        n_seen_comp      = r_seen_comp;

        o_result.new_target         = i_target_position;
        o_result.target_moved       = 1'b0;
        o_result.conversion_request = 1'b0;

        if (w_active) begin
            if ((w_switch_on || r_read_phase) && w_in_range) begin
                n_last_good_temp = i_sensor_reading;
            end
            n_seen_comp    = i_cfg.comp_enable;
            n_held_reading = w_held;
            n_read_phase   = !r_read_phase;
            n_reference_temp = w_event ? w_held : w_ref;
            o_result.conversion_request = !r_read_phase;
            if (w_event) begin
                o_result.new_target   = w_target;
                o_result.target_moved = 1'b1;
            end
        end
        o_result.reported_temp = n_last_good_temp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_good_temp <= '0;
            r_held_reading   <= '0;
            r_reference_temp <= '0;
            r_read_phase     <= 1'b0;
            r_seen_comp      <= 1'b0;
        end else if (i_valid) begin
            r_last_good_temp <= n_last_good_temp;
            r_held_reading   <= n_held_reading;
            r_reference_temp <= n_reference_temp;
            r_read_phase     <= n_read_phase;
            r_seen_comp      <= n_seen_comp;
        end
    end

    // A kept temperature is always one that passed the range check, or the reset zero
    a_last_good_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_last_good_temp > TEMP_LOW_LIMIT) && (r_last_good_temp < TEMP_HIGH_LIMIT))
        else $error("last good temperature out of range");

    // A moved target never exceeds the upper clamp
    a_move_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_result.target_moved) |-> (o_result.new_target <= i_cfg.max_position))
        else $error("compensated target above max position");

    // Phase advances only on a processed tick with the probe active
    a_phase_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_valid && w_active) |=> $stable(r_read_phase))
        else $error("read phase moved without an active tick");

    // An idle probe leaves the target untouched
    a_idle_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_active |-> (!o_result.target_moved && !o_result.conversion_request))
        else $error("inactive probe produced activity");

endmodule : fcomp_core

`default_nettype wire
